// ----- rtl/core/drt_pkg.sv -----
// Shared types and constants for the damage rectangle tracker.
package drt_pkg;

   localparam int MAX_RECTS   = 32;
   localparam int IDX_W       = $clog2(MAX_RECTS + 1);
   localparam int SLOT_W      = $clog2(MAX_RECTS);
   localparam int CNT_W       = 6;
   localparam int COORD_W     = 15;
   localparam int AREA_W      = 2 * COORD_W;
   localparam int SUM_W       = AREA_W + IDX_W;
   localparam logic [COORD_W-1:0] SCREEN_LIMIT = 15'd16384;

   // Command codes
   localparam logic [2:0] CMD_ADD     = 3'd0;
   localparam logic [2:0] CMD_QUERY   = 3'd1;
   localparam logic [2:0] CMD_CONSUME = 3'd2;
   localparam logic [2:0] CMD_REMOVE  = 3'd3;
   localparam logic [2:0] CMD_CLEAR   = 3'd4;
   localparam logic [2:0] CMD_LIST    = 3'd5;

   // Register indexes
   localparam logic CSR_WIDTH  = 1'b0;
   localparam logic CSR_HEIGHT = 1'b1;

   // One stored rectangle, all values within the clipped screen
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] w;
      logic [COORD_W-1:0] h;
   } rect_type;

endpackage

// ----- rtl/core/drt_pair_unit.sv -----
// Shared pair evaluator: bounding box, areas of both and of the box, and overlap of two rectangles.
module drt_pair_unit
   import drt_pkg::*;
(
   input  logic              clock,
   input  rect_type          rect_a,
   input  rect_type          rect_b,
   output rect_type          bound_ff,
   output logic [AREA_W-1:0] area_a_ff,
   output logic [AREA_W-1:0] area_b_ff,
   output logic [AREA_W-1:0] area_c_ff,
   output logic              overlap_ff
);

   logic [COORD_W:0] ra, rb, ba, bb, rt, bt;
   logic [COORD_W-1:0] lx, ty;
   rect_type         bound_in;

   // bounding box; right and bottom edges stay within 2^15
   always_comb begin
      ra = {1'b0, rect_a.x} + {1'b0, rect_a.w};
      rb = {1'b0, rect_b.x} + {1'b0, rect_b.w};
      ba = {1'b0, rect_a.y} + {1'b0, rect_a.h};
      bb = {1'b0, rect_b.y} + {1'b0, rect_b.h};
      rt = (ra > rb) ? ra : rb;
      bt = (ba > bb) ? ba : bb;
      lx = (rect_a.x < rect_b.x) ? rect_a.x : rect_b.x;
      ty = (rect_a.y < rect_b.y) ? rect_a.y : rect_b.y;
      bound_in.x = lx;
      bound_in.y = ty;
      bound_in.w = COORD_W'(rt - {1'b0, lx});
      bound_in.h = COORD_W'(bt - {1'b0, ty});
   end

   // three 15x15 products, registered
   always_ff @(posedge clock) begin
      bound_ff   <= bound_in;
      area_a_ff  <= rect_a.w * rect_a.h;
      area_b_ff  <= rect_b.w * rect_b.h;
      area_c_ff  <= bound_in.w * bound_in.h;
      overlap_ff <= ({1'b0, rect_a.x} < rb) && ({1'b0, rect_b.x} < ra) &&
                    ({1'b0, rect_a.y} < bb) && ({1'b0, rect_b.y} < ba);
   end

endmodule

// ----- rtl/core/damage_rectangle_tracker.sv -----
// Top level: damage rectangle list with command sequencer and shared pair unit.
// Query, remove and list walk the stored entries, and an output stall lengthens any command. An
//   add evaluates each scanned pair in a PAIR and an EVAL state, runs coalescing passes, shifts
//   entries down after each merge and then sums the stored areas.
// Throughput: one command at a time; req_tready is low while a command works.
// The pair scan through the single shared evaluator sets the add time.
// Reset (synchronous, active high) empties the list and clears full-screen.
module damage_rectangle_tracker
   import drt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // cmd[2:0], rect_x, rect_y, rect_w, rect_h, zero pad
   input  logic        rsp_tready,
   output logic        rsp_tvalid,
   output logic [71:0] rsp_tdata,   // ok, out_x, out_y, out_w, out_h, entry_count,
                                    // full_screen, zero pad
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [14:0] csr_wdata
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_RD    = 13'b0000000000010,
      ST_PAIR  = 13'b0000000000100,
      ST_EVAL  = 13'b0000000001000,
      ST_SHIFT = 13'b0000000010000,
      ST_SUM   = 13'b0000000100000,
      ST_QRY   = 13'b0000001000000,
      ST_LIST  = 13'b0000010000000,
      ST_OUT   = 13'b0000100000000,
      ST_WAIT  = 13'b0001000000000,
      ST_FULL  = 13'b0010000000000,
      ST_MERGE = 13'b0100000000000,
      ST_DROP  = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   logic [COORD_W-1:0] scr_w_ff, scr_h_ff, sw, sh;
   rect_type           store_ff [MAX_RECTS];
   rect_type           spare_ff;    // extra slot for the new rectangle on a full list
   logic [IDX_W-1:0]   count_ff, count_in;
   logic               full_ff, full_in;

   logic [2:0]         cmd_ff;
   logic signed [15:0] qx_ff, qy_ff;
   logic [15:0]        qw_ff, qh_ff;
   logic [IDX_W-1:0]   i_ff, i_in, j_ff, j_in, bi_ff, bi_in, bj_ff, bj_in, k_ff, k_in;
   logic               bfull_ff, bfull_in;
   logic signed [AREA_W+1:0] cost_ff, cost_in;
   logic [AREA_W-1:0]  barea_ff, barea_in;
   logic               hit_ff, hit_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   rect_type           merge_ff, merge_in;
   logic               okr_ff, okr_in;

   logic [71:0]        out_ff, out_in;
   logic               ov_ff, ov_in, ol_ff, ol_in;

   rect_type           pa, pb, pbound;
   logic [AREA_W-1:0]  ar_a, ar_b, ar_c;
   logic               pov;

   // store read ports
   logic [IDX_W-1:0]   k_nx;
   rect_type           rk, rk1;
   logic [AREA_W-1:0]  k_area, scr_area;

   // store write port
   logic               st_we;
   logic [IDX_W-1:0]   st_wa;
   rect_type           st_wd;

   assign sw = (scr_w_ff > SCREEN_LIMIT) ? SCREEN_LIMIT : scr_w_ff;
   assign sh = (scr_h_ff > SCREEN_LIMIT) ? SCREEN_LIMIT : scr_h_ff;

   // slot MAX_RECTS lives in the spare register
   assign pa   = (i_ff == IDX_W'(MAX_RECTS)) ? spare_ff : store_ff[i_ff[SLOT_W-1:0]];
   assign pb   = (j_ff == IDX_W'(MAX_RECTS)) ? spare_ff : store_ff[j_ff[SLOT_W-1:0]];
   assign rk   = (k_ff == IDX_W'(MAX_RECTS)) ? spare_ff : store_ff[k_ff[SLOT_W-1:0]];
   assign k_nx = k_ff + 1'b1;
   assign rk1  = (k_nx == IDX_W'(MAX_RECTS)) ? spare_ff : store_ff[k_nx[SLOT_W-1:0]];

   assign k_area   = rk.w * rk.h;
   assign scr_area = sw * sh;

   drt_pair_unit u_pair (
      .clock(clock), .rect_a(pa), .rect_b(pb), .bound_ff(pbound),
      .area_a_ff(ar_a), .area_b_ff(ar_b), .area_c_ff(ar_c), .overlap_ff(pov)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = ol_ff;

   // clip of the incoming add
   logic signed [17:0] cl, ct, cr, cb, xr, yb;
   rect_type           clip;
   logic               clip_ok, clip_full;
   always_comb begin
      xr = 18'(qx_ff) + 18'($signed({2'b0, qw_ff}));
      yb = 18'(qy_ff) + 18'($signed({2'b0, qh_ff}));
      cl = (qx_ff < 0) ? 18'sd0 : 18'(qx_ff);
      ct = (qy_ff < 0) ? 18'sd0 : 18'(qy_ff);
      cr = (xr > $signed({3'b0, sw})) ? $signed({3'b0, sw}) : xr;
      cb = (yb > $signed({3'b0, sh})) ? $signed({3'b0, sh}) : yb;
      clip_ok = (qw_ff != 16'd0) && (qh_ff != 16'd0) && (sw != '0) && (sh != '0) &&
                (cr > cl) && (cb > ct);
      clip.x = COORD_W'(cl);
      clip.y = COORD_W'(ct);
      clip.w = COORD_W'(cr - cl);
      clip.h = COORD_W'(cb - ct);
      clip_full = (clip.x == '0) && (clip.y == '0) && (clip.w == sw) && (clip.h == sh);
   end

   // pair decision values
   logic [AREA_W:0]          la_ra, extra;
   logic [AREA_W-1:0]        small_area;
   logic                     take;
   logic signed [AREA_W+1:0] cost;
   always_comb begin
      la_ra = {1'b0, ar_a} + {1'b0, ar_b};
      extra = ({1'b0, ar_c} > la_ra) ? ({1'b0, ar_c} - la_ra) : '0;
      small_area = (ar_a < ar_b) ? ar_a : ar_b;
      take  = (extra == '0) || (pov && (extra <= {3'b0, small_area[AREA_W-1:2]}));
      cost  = $signed({2'b0, ar_c}) - $signed({2'b0, ar_a}) - $signed({2'b0, ar_b});
   end

   rect_type front;
   logic     fr_full, q_ov;
   logic [16:0] fy_sum;
   always_comb begin
      front   = store_ff[0];
      fr_full = (front.x == '0) && (front.y == '0) && (front.w == sw) && (front.h == sh);
      q_ov = ($signed({3'b0, rk.x}) < xr) &&
             (18'(qx_ff) < $signed({3'b0, rk.x}) + $signed({3'b0, rk.w})) &&
             ($signed({3'b0, rk.y}) < yb) &&
             (18'(qy_ff) < $signed({3'b0, rk.y}) + $signed({3'b0, rk.h}));
      fy_sum = 17'(store_ff[0].y) + 17'(qh_ff);
   end

   function automatic logic [71:0] pack_out(input logic ok, input rect_type r,
                                            input logic [IDX_W-1:0] n, input logic f);
      pack_out = {6'b0, f, CNT_W'(n), r.h, r.w, r.y[13:0], r.x[13:0], ok};
   endfunction

   rect_type zero_rect;
   assign zero_rect = '0;

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff; full_in = full_ff;
      i_in = i_ff; j_in = j_ff; bi_in = bi_ff; bj_in = bj_ff; k_in = k_ff;
      bfull_in = bfull_ff; cost_in = cost_ff; barea_in = barea_ff;
      hit_in = hit_ff; sum_in = sum_ff; merge_in = merge_ff; okr_in = okr_ff;
      out_in = out_ff; ov_in = ov_ff; ol_in = ol_ff;
      st_we = 1'b0; st_wa = '0; st_wd = clip;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               k_in = '0; hit_in = 1'b0;
               case (req_tdata[2:0])
                  CMD_ADD:     state_in = ST_RD;
                  CMD_QUERY:   state_in = ST_QRY;
                  CMD_LIST:    state_in = ST_LIST;
                  default:     state_in = ST_RD;
               endcase
            end
         end
         ST_RD: begin
            state_in = ST_OUT;
            case (cmd_ff)
               CMD_ADD: begin
                  if (clip_ok) begin
                     if (clip_full) state_in = ST_FULL;
                     else if (full_ff && count_ff == IDX_W'(1) && fr_full) state_in = ST_OUT;
                     else begin
                        st_we = 1'b1; st_wa = count_ff;
                        bfull_in = (count_ff == IDX_W'(MAX_RECTS));
                        count_in = count_ff + 1'b1;
                        i_in = '0; j_in = IDX_W'(1);
                        cost_in = {1'b0, {(AREA_W+1){1'b1}}};
                        barea_in = '1;
                        bi_in = '0; bj_in = IDX_W'(1);
                        state_in = ST_PAIR;
                     end
                  end
               end
               CMD_CONSUME: begin
                  if (count_ff != '0 && qw_ff != '0 && qh_ff != '0 &&
                      qx_ff == $signed({1'b0, front.x}) && qy_ff == $signed({1'b0, front.y}) &&
                      qw_ff == {1'b0, front.w}) begin
                     if (qh_ff == {1'b0, front.h}) begin
                        okr_in = 1'b1; k_in = '0; state_in = ST_DROP;
                     end else if (qh_ff < {1'b0, front.h}) begin
                        okr_in = 1'b1;
                        st_we = 1'b1; st_wa = '0;
                        st_wd = front;
                        st_wd.y = COORD_W'(fy_sum);
                        st_wd.h = front.h - COORD_W'(qh_ff);
                        full_in = 1'b0;
                     end
                  end
               end
               CMD_REMOVE: begin
                  okr_in = 1'b0;
                  if (count_ff != '0) begin k_in = '0; state_in = ST_DROP; end
               end
               CMD_CLEAR: begin count_in = '0; full_in = 1'b0; end
               default: ;
            endcase
         end
         ST_DROP: begin
            // shift entries down over the dropped slot, one per cycle
            if (k_ff + 1'b1 < count_ff) begin
               st_we = 1'b1; st_wa = k_ff; st_wd = rk1;
               k_in = k_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               if (cmd_ff == CMD_REMOVE || cmd_ff == CMD_CONSUME) begin
                  if (count_ff == IDX_W'(1)) full_in = 1'b0;
               end
               if (cmd_ff == CMD_ADD) begin
                  i_in = '0; j_in = IDX_W'(1); state_in = ST_PAIR;
               end else state_in = ST_OUT;
            end
         end
         ST_PAIR: begin
            if (count_ff < IDX_W'(2) || i_ff + 1'b1 >= count_ff) begin
               if (bfull_ff) state_in = ST_MERGE;
               else begin k_in = '0; sum_in = '0; state_in = ST_SUM; end
            end else state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (bfull_ff) begin
               // keep the bounding box of the cheapest pair so far
               if (cost < cost_ff || (cost == cost_ff && ar_c < barea_ff)) begin
                  cost_in = cost; barea_in = ar_c; bi_in = i_ff; bj_in = j_ff;
                  merge_in = pbound;
               end
            end else if (take) begin
               st_we = 1'b1; st_wa = i_ff; st_wd = pbound;
               k_in = j_ff; state_in = ST_SHIFT;
            end
            if (state_in == ST_EVAL) begin
               state_in = ST_PAIR;
               if (j_ff + 1'b1 < count_ff) j_in = j_ff + 1'b1;
               else begin i_in = i_ff + 1'b1; j_in = i_ff + 2'd2; end
            end
         end
         ST_MERGE: begin
            // full list: merge the cheapest pair, then coalesce
            st_we = 1'b1; st_wa = bi_ff; st_wd = merge_ff;
            bfull_in = 1'b0; k_in = bj_ff; state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (k_ff + 1'b1 < count_ff) begin
               st_we = 1'b1; st_wa = k_ff; st_wd = rk1;
               k_in = k_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               i_in = '0; j_in = IDX_W'(1); state_in = ST_PAIR;
            end
         end
         ST_SUM: begin
            if (k_ff < count_ff) begin
               sum_in = sum_ff + SUM_W'(k_area);
               k_in = k_ff + 1'b1;
            end else begin
               if (sum_ff >= SUM_W'(scr_area)) state_in = ST_FULL;
               else state_in = ST_OUT;
            end
         end
         ST_FULL: begin
            st_we = 1'b1; st_wa = '0;
            st_wd.x = '0; st_wd.y = '0; st_wd.w = sw; st_wd.h = sh;
            count_in = IDX_W'(1); full_in = 1'b1; state_in = ST_OUT;
         end
         ST_QRY: begin
            if (k_ff < count_ff) begin
               if (qw_ff != '0 && qh_ff != '0 && q_ov) hit_in = 1'b1;
               k_in = k_ff + 1'b1;
            end else state_in = ST_OUT;
         end
         ST_LIST: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1;
               if (count_ff == '0) begin
                  out_in = pack_out(1'b0, zero_rect, count_ff, full_ff);
                  ol_in = 1'b1; state_in = ST_WAIT;
               end else begin
                  out_in = pack_out(1'b1, rk, count_ff, full_ff);
                  ol_in = (k_ff + 1'b1 == count_ff);
                  k_in = k_ff + 1'b1;
                  if (k_ff + 1'b1 == count_ff) state_in = ST_WAIT;
               end
            end
         end
         ST_OUT: begin
            if (!ov_ff || rsp_tready) begin
               ov_in = 1'b1; ol_in = 1'b1;
               out_in = pack_out(
                  (cmd_ff == CMD_QUERY) ? hit_ff :
                  (cmd_ff == CMD_CONSUME) ? okr_ff :
                  (cmd_ff == CMD_CLEAR) ? 1'b0 : (count_ff != '0),
                  (count_ff != '0) ? store_ff[0] : zero_rect, count_ff, full_ff);
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: if (!ov_ff || rsp_tready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         full_ff  <= 1'b0;
         ov_ff    <= 1'b0;
         scr_w_ff <= 15'd1920;
         scr_h_ff <= 15'd1080;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         full_ff  <= full_in;
         ov_ff    <= ov_in;
         if (csr_we && csr_index == CSR_WIDTH)  scr_w_ff <= csr_wdata;
         if (csr_we && csr_index == CSR_HEIGHT) scr_h_ff <= csr_wdata;
      end
   end

   // working registers and store
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_tvalid) begin
         cmd_ff <= req_tdata[2:0];
         qx_ff  <= req_tdata[18:3];
         qy_ff  <= req_tdata[34:19];
         qw_ff  <= req_tdata[50:35];
         qh_ff  <= req_tdata[66:51];
         okr_ff <= 1'b0;
      end else okr_ff <= okr_in;
      i_ff <= i_in; j_ff <= j_in; bi_ff <= bi_in; bj_ff <= bj_in; k_ff <= k_in;
      bfull_ff <= bfull_in; cost_ff <= cost_in; barea_ff <= barea_in;
      hit_ff <= hit_in; sum_ff <= sum_in; merge_ff <= merge_in;
      out_ff <= out_in; ol_ff <= ol_in;
      if (st_we) begin
         if (st_wa == IDX_W'(MAX_RECTS)) spare_ff <= st_wd;
         else store_ff[st_wa[SLOT_W-1:0]] <= st_wd;
      end
   end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the damage rectangle tracker: stimulus, predictor and checker.
`timescale 1ns / 100ps

module tb_top;
   import drt_pkg::*;

   typedef struct {
      longint x, y, w, h;
   } box_t;

   // Expected response: ok, x, y, w, h, count, full flag, tlast
   typedef struct {
      bit          ok;
      bit [13:0]   x;
      bit [13:0]   y;
      bit [14:0]   w;
      bit [14:0]   h;
      bit [5:0]    cnt;
      bit          full;
      bit          last;
   } rsp_t;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;
   logic        rsp_tready;
   logic        rsp_tvalid;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_we;
   logic        csr_index;
   logic [14:0] csr_wdata;

   damage_rectangle_tracker dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tready(rsp_tready), .rsp_tvalid(rsp_tvalid), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor state
   box_t    rects[0:MAX_RECTS];
   int      rect_cnt;
   bit      full_flag;
   longint  scr_width_reg, scr_height_reg;

   logic [71:0] pending_reqs[$];
   rsp_t        expected_rsps[$];
   int          errors, n_items, n_rsps, idle_cycles;
   bit          req_taken, no_idle, stall_request;
   int          req_gap, rsp_gap, rsp_hold;

   // Clock
   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   function automatic longint scr_w();
      return (scr_width_reg > 16384) ? 16384 : scr_width_reg;
   endfunction

   function automatic longint scr_h();
      return (scr_height_reg > 16384) ? 16384 : scr_height_reg;
   endfunction

   function automatic longint lmin(longint a, longint b);
      return a < b ? a : b;
   endfunction

   function automatic longint lmax(longint a, longint b);
      return a > b ? a : b;
   endfunction

   function automatic longint area(box_t b);
      return b.w * b.h;
   endfunction

   function automatic bit is_full_box(box_t b);
      return b.x == 0 && b.y == 0 && b.w == scr_w() && b.h == scr_h();
   endfunction

   function automatic bit overlap(box_t a, box_t b);
      return a.x < b.x + b.w && b.x < a.x + a.w && a.y < b.y + b.h && b.y < a.y + a.h;
   endfunction

   function automatic box_t bbox(box_t a, box_t b);
      box_t r;
      r.x = lmin(a.x, b.x);
      r.y = lmin(a.y, b.y);
      r.w = lmax(a.x + a.w, b.x + b.w) - r.x;
      r.h = lmax(a.y + a.h, b.y + b.h) - r.y;
      return r;
   endfunction

   function automatic void drop_rect(int n, int idx);
      for (int k = idx + 1; k < n; k++) rects[k-1] = rects[k];
   endfunction

   // Repeatedly merge the first pair that adds no area or overlaps cheaply
   function automatic void merge_pairs();
      bit merged;
      box_t c;
      longint la, ra, ca, extra, sm;
      bit limited;
      merged = 1;
      while (merged) begin
         merged = 0;
         for (int i = 0; i < rect_cnt && !merged; i++) begin
            for (int j = i + 1; j < rect_cnt; j++) begin
               c = bbox(rects[i], rects[j]);
               la = area(rects[i]);
               ra = area(rects[j]);
               ca = area(c);
               extra = (ca > la + ra) ? ca - la - ra : 0;
               sm = la < ra ? la : ra;
               limited = overlap(rects[i], rects[j]) && extra <= sm / 4;
               if (extra != 0 && !limited) continue;
               rects[i] = c;
               drop_rect(rect_cnt, j);
               rect_cnt--;
               merged = 1;
               break;
            end
         end
      end
   endfunction

   function automatic void mark_full();
      rects[0].x = 0;
      rects[0].y = 0;
      rects[0].w = scr_w();
      rects[0].h = scr_h();
      rect_cnt = 1;
      full_flag = 1;
   endfunction

   function automatic void add_rect(longint x, longint y, longint w, longint h);
      longint l, t, r, b, sum, best_cost, best_area, ma, cost;
      box_t c;
      int bi, bj;
      if (w == 0 || h == 0 || scr_w() == 0 || scr_h() == 0) return;
      l = lmax(0, x);
      t = lmax(0, y);
      r = lmin(scr_w(), x + w);
      b = lmin(scr_h(), y + h);
      if (r <= l || b <= t) return;
      c.x = l; c.y = t; c.w = r - l; c.h = b - t;
      if (is_full_box(c)) begin
         mark_full();
         return;
      end
      if (full_flag && rect_cnt == 1 && is_full_box(rects[0])) return;
      if (rect_cnt < MAX_RECTS) begin
         rects[rect_cnt] = c;
         rect_cnt++;
         merge_pairs();
      end else begin
         // list full: merge the cheapest pair among the list plus the new one
         bi = 0; bj = 1;
         best_cost = 64'h7FFF_FFFF_FFFF_FFFF;
         best_area = 64'h7FFF_FFFF_FFFF_FFFF;
         rects[MAX_RECTS] = c;
         for (int i = 0; i <= MAX_RECTS; i++) begin
            for (int j = i + 1; j <= MAX_RECTS; j++) begin
               ma = area(bbox(rects[i], rects[j]));
               cost = ma - area(rects[i]) - area(rects[j]);
               if (cost < best_cost || (cost == best_cost && ma < best_area)) begin
                  bi = i; bj = j; best_cost = cost; best_area = ma;
               end
            end
         end
         rects[bi] = bbox(rects[bi], rects[bj]);
         drop_rect(MAX_RECTS + 1, bj);
         rect_cnt = MAX_RECTS;
         merge_pairs();
      end
      sum = 0;
      for (int k = 0; k < rect_cnt; k++) sum += area(rects[k]);
      if (sum >= scr_w() * scr_h()) mark_full();
   endfunction

   function automatic void pop_front_rect();
      if (rect_cnt == 0) return;
      drop_rect(rect_cnt, 0);
      rect_cnt--;
      if (rect_cnt == 0) full_flag = 0;
   endfunction

   function automatic void push_rsp(bit ok, bit has_box, box_t b, bit last);
      rsp_t e;
      e.ok   = ok;
      e.x    = has_box ? b.x[13:0] : '0;
      e.y    = has_box ? b.y[13:0] : '0;
      e.w    = has_box ? b.w[14:0] : '0;
      e.h    = has_box ? b.h[14:0] : '0;
      e.cnt  = rect_cnt[5:0];
      e.full = full_flag;
      e.last = last;
      expected_rsps.push_back(e);
   endfunction

   // Apply one accepted command to the tracker state and queue its responses
   function automatic void track_command(logic [71:0] d);
      logic [2:0] cmd;
      longint x, y, w, h;
      bit ok;
      box_t q, f;
      cmd = d[2:0];
      x = longint'($signed(d[18:3]));
      y = longint'($signed(d[34:19]));
      w = longint'(d[50:35]);
      h = longint'(d[66:51]);
      ok = 0;
      case (cmd)
         CMD_ADD: begin
            add_rect(x, y, w, h);
            ok = rect_cnt > 0;
         end
         CMD_QUERY: begin
            if (w != 0 && h != 0) begin
               q.x = x; q.y = y; q.w = w; q.h = h;
               for (int k = 0; k < rect_cnt; k++)
                  if (overlap(rects[k], q)) ok = 1;
            end
         end
         CMD_CONSUME: begin
            if (rect_cnt != 0 && w != 0 && h != 0) begin
               f = rects[0];
               if (x == f.x && y == f.y && w == f.w && h == f.h) begin
                  pop_front_rect();
                  ok = 1;
               end else if (x == f.x && y == f.y && w == f.w && h < f.h) begin
                  // keep the part below the consumed stripe
                  rects[0].y += h;
                  rects[0].h -= h;
                  full_flag = 0;
                  ok = 1;
               end
            end
         end
         CMD_REMOVE: begin
            pop_front_rect();
            ok = rect_cnt > 0;
         end
         CMD_CLEAR: begin
            rect_cnt = 0;
            full_flag = 0;
         end
         CMD_LIST: begin
            if (rect_cnt == 0) push_rsp(0, 0, rects[0], 1);
            for (int k = 0; k < rect_cnt; k++)
               push_rsp(1, 1, rects[k], k + 1 == rect_cnt);
            return;
         end
         default: ok = rect_cnt > 0;
      endcase
      push_rsp(ok, rect_cnt != 0, rects[0], 1);
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Request driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
      end else if (req_tvalid && !req_taken) begin
         // hold the offered transaction
      end else if (req_gap > 0) begin
         req_gap <= req_gap - 1;
         req_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
         req_tdata <= pending_reqs.pop_front();
         req_tvalid <= 1'b1;
         req_gap <= pick_gap();
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // Response receiver with random and long stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap <= 0;
         rsp_hold <= 0;
      end else if (stall_request) begin
         stall_request = 0;
         rsp_hold <= 4000;
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         rsp_gap <= pick_gap();
      end
   end

   // Input capture, output checking and watchdog
   always @(posedge clock) begin
      rsp_t e;
      req_taken <= req_tvalid && req_tready && !reset;
      if (!reset && req_tvalid && req_tready) begin
         track_command(req_tdata);
         n_items++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_rsps++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected response %h last %b", $realtime, rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            e = expected_rsps.pop_front();
            if (rsp_tdata[0] !== e.ok || rsp_tdata[14:1] !== e.x ||
                rsp_tdata[28:15] !== e.y || rsp_tdata[43:29] !== e.w ||
                rsp_tdata[58:44] !== e.h || rsp_tdata[64:59] !== e.cnt ||
                rsp_tdata[65] !== e.full || rsp_tlast !== e.last) begin
               $display("%0t: expected ok %0d x %0d y %0d w %0d h %0d cnt %0d full %0d last %0d",
                        $realtime, e.ok, e.x, e.y, e.w, e.h, e.cnt, e.full, e.last);
               $display("%0t: actual   ok %0d x %0d y %0d w %0d h %0d cnt %0d full %0d last %0d",
                        $realtime, rsp_tdata[0], rsp_tdata[14:1], rsp_tdata[28:15],
                        rsp_tdata[43:29], rsp_tdata[58:44], rsp_tdata[64:59], rsp_tdata[65],
                        rsp_tlast);
               errors++;
            end
         end
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 300000) begin
         $display("watchdog expired with %0d responses outstanding", expected_rsps.size());
         $display("damage_rectangle_tracker: mismatch");
         $finish;
      end
   end

   function automatic logic [71:0] pack_req(logic [2:0] cmd, logic [15:0] x, logic [15:0] y,
                                            logic [15:0] w, logic [15:0] h);
      return {5'b0, h, w, y, x, cmd};
   endfunction

   // Wait until all transactions are done and the block has settled
   task automatic wait_idle();
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_rsps.size() == 0);
      repeat (30) @(posedge clock);
   endtask

   task automatic write_screen(int w, int h);
      wait_idle();
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= CSR_WIDTH; csr_wdata <= w[14:0];
      @(negedge clock);
      csr_index <= CSR_HEIGHT; csr_wdata <= h[14:0];
      @(negedge clock);
      csr_we <= 1'b0;
      scr_width_reg = longint'(w[14:0]);
      scr_height_reg = longint'(h[14:0]);
   endtask

   // One random command; most adds land on screen, some use raw fields
   task automatic random_command();
      int r, sw, sh;
      logic [15:0] x, y, w, h;
      box_t f;
      r = $urandom_range(0, 99);
      sw = int'(lmax(1, scr_w()));
      sh = int'(lmax(1, scr_h()));
      if ($urandom_range(0, 4) == 0) begin
         x = 16'($urandom); y = 16'($urandom); w = 16'($urandom); h = 16'($urandom);
      end else begin
         x = 16'($urandom_range(0, sw - 1));
         y = 16'($urandom_range(0, sh - 1));
         w = 16'($urandom_range(1, (sw < 4) ? 1 : sw / 4));
         h = 16'($urandom_range(1, (sh < 4) ? 1 : sh / 4));
      end
      if (r < 50) pending_reqs.push_back(pack_req(CMD_ADD, x, y, w, h));
      else if (r < 60) pending_reqs.push_back(pack_req(CMD_QUERY, x, y, w, h));
      else if (r < 72) begin
         if ($urandom_range(0, 1)) begin
            // synchronize so the front entry is known, then consume it
            wait_idle();
            f = rects[0];
            if (rect_cnt != 0) begin
               x = 16'(f.x); y = 16'(f.y); w = 16'(f.w);
               h = (f.h > 1 && $urandom_range(0, 1)) ? 16'($urandom_range(1, int'(f.h - 1)))
                                                      : 16'(f.h);
            end
         end
         pending_reqs.push_back(pack_req(CMD_CONSUME, x, y, w, h));
      end
      else if (r < 80) pending_reqs.push_back(pack_req(CMD_REMOVE, x, y, w, h));
      else if (r < 83) pending_reqs.push_back(pack_req(CMD_CLEAR, x, y, w, h));
      else if (r < 93) pending_reqs.push_back(pack_req(CMD_LIST, x, y, w, h));
      else pending_reqs.push_back(pack_req(3'($urandom_range(6, 7)), x, y, w, h));
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         random_command();
         if (pending_reqs.size() > 8) wait (pending_reqs.size() < 4);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_WIDTH;
      csr_wdata = '0;
      rect_cnt = 0;
      full_flag = 0;
      scr_width_reg = 1920;
      scr_height_reg = 1080;
      errors = 0; n_items = 0; n_rsps = 0; idle_cycles = 0;
      req_taken = 0; no_idle = 0; stall_request = 0;
      for (int k = 0; k <= MAX_RECTS; k++) rects[k] = '{0, 0, 0, 0};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty list, extremes, every command and a stripe consume
      pending_reqs.push_back(pack_req(CMD_LIST, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(CMD_REMOVE, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(CMD_CONSUME, 0, 0, 1, 1));
      pending_reqs.push_back(pack_req(CMD_ADD, 5, 5, 0, 10));
      pending_reqs.push_back(pack_req(CMD_ADD, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(pack_req(CMD_ADD, 10, 10, 20, 20));
      pending_reqs.push_back(pack_req(CMD_LIST, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(CMD_CLEAR, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(CMD_ADD, 10, 10, 20, 20));
      pending_reqs.push_back(pack_req(CMD_ADD, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(pack_req(CMD_ADD, 16'hFFF0, 16'hFFF0, 20, 20));
      pending_reqs.push_back(pack_req(CMD_ADD, 20, 10, 20, 20));
      pending_reqs.push_back(pack_req(CMD_QUERY, 15, 15, 1, 1));
      pending_reqs.push_back(pack_req(CMD_QUERY, 15, 15, 0, 1));
      pending_reqs.push_back(pack_req(CMD_QUERY, 1000, 900, 5, 5));
      pending_reqs.push_back(pack_req(CMD_LIST, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(3'd6, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(3'd7, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(CMD_CONSUME, 0, 0, 20, 20));
      pending_reqs.push_back(pack_req(CMD_LIST, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(CMD_REMOVE, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(CMD_ADD, 0, 0, 1920, 1080));
      pending_reqs.push_back(pack_req(CMD_ADD, 3, 3, 3, 3));
      pending_reqs.push_back(pack_req(CMD_CONSUME, 0, 0, 1920, 100));
      wait_idle();

      // Stripe then exact consume of a known front entry
      pending_reqs.push_back(pack_req(CMD_CLEAR, 0, 0, 0, 0));
      pending_reqs.push_back(pack_req(CMD_ADD, 10, 10, 20, 20));
      pending_reqs.push_back(pack_req(CMD_CONSUME, 10, 10, 20, 5));
      pending_reqs.push_back(pack_req(CMD_CONSUME, 10, 15, 20, 15));
      random_phase(30);

      // Small screen: merges, full list and full-screen promotion
      write_screen(64, 48);
      random_phase(70);

      // Long receiver stall while the sender keeps offering transactions
      wait_idle();
      no_idle = 1;
      stall_request = 1;
      for (int i = 0; i < 12; i++) begin
         pending_reqs.push_back(pack_req(CMD_LIST, 0, 0, 0, 0));
         pending_reqs.push_back(pack_req(CMD_QUERY, 0, 0, 16'hFFFF, 16'hFFFF));
      end
      wait_idle();
      no_idle = 0;

      write_screen(0, 100);
      random_phase(15);
      write_screen(32767, 32767);
      random_phase(25);
      write_screen(16384, 16384);
      random_phase(25);
      write_screen(1, 1);
      random_phase(15);
      write_screen(200, 120);
      no_idle = 1;
      random_phase(20);
      no_idle = 0;
      random_phase(40);

      wait_idle();
      repeat (100) @(posedge clock);
      $display("covered %0d commands and %0d responses over seven screen settings", n_items,
               n_rsps);
      $display("including a long response stall and consumes of the known front entry");
      if (errors == 0) begin
         $display("damage_rectangle_tracker: match");
      end else begin
         $display("damage_rectangle_tracker: mismatch");
      end
      $finish;
   end

endmodule
